// ----- rtl/core/cbt_pkg.sv -----
// shared types and constants for the callback timer with extend
package cbt_pkg;

  localparam int unsigned CountWidth = 32;
  localparam int unsigned TimeWidth  = 32;
  localparam int unsigned WideWidth  = (CountWidth > TimeWidth) ? CountWidth : TimeWidth;
  localparam logic [CountWidth-1:0] CountMax = {CountWidth{1'b1}};

  typedef enum logic [2:0] {
    CmdTick   = 3'd0,
    CmdStart  = 3'd1,
    CmdReset  = 3'd2,
    CmdExtend = 3'd3,
    CmdCancel = 3'd4,
    CmdKill   = 3'd5
  } command_e;

  typedef enum logic [1:0] {
    EvNone   = 2'd0,
    EvNormal = 2'd1,
    EvCancel = 2'd2
  } event_e;

  typedef struct packed {
    logic [2:0]           command;
    logic [TimeWidth-1:0] time_value;
  } cmd_item_t;

  typedef struct packed {
    logic [1:0] event_res;
    logic       running;
  } result_item_t;

  typedef struct packed {
    logic                  armed;
    logic [CountWidth-1:0] elapsed_ticks;
    logic [CountWidth-1:0] timeout_ticks;
  } timer_state_t;

endpackage

// ----- rtl/core/cbt_step.sv -----
// next timer state and result for one command item
module cbt_step (
  input  cbt_pkg::timer_state_t state_i,
  input  cbt_pkg::cmd_item_t    item_i,
  input  logic                  periodic_i,
  output cbt_pkg::timer_state_t state_o,
  output cbt_pkg::result_item_t result_o
);

  logic [cbt_pkg::WideWidth-1:0]  time_wide;
  logic [cbt_pkg::CountWidth-1:0] time_sat;
  logic [cbt_pkg::CountWidth-1:0] remaining;
  cbt_pkg::timer_state_t          st;
  cbt_pkg::event_e                ev;

  // saturate the time value to the counter width
  assign time_wide = cbt_pkg::WideWidth'(item_i.time_value);
  assign time_sat  = (time_wide > cbt_pkg::WideWidth'(cbt_pkg::CountMax)) ?
                     cbt_pkg::CountMax : cbt_pkg::CountWidth'(time_wide);

  assign remaining = (state_i.timeout_ticks > state_i.elapsed_ticks) ?
                     (state_i.timeout_ticks - state_i.elapsed_ticks) : '0;

  always_comb begin
    st = state_i;
    ev = cbt_pkg::EvNone;
    if (!state_i.armed) begin
      if (cbt_pkg::command_e'(item_i.command) == cbt_pkg::CmdStart) begin
        st.timeout_ticks = time_sat;
        st.elapsed_ticks = '0;
        st.armed         = 1'b1;
      end
    end else begin
      unique case (cbt_pkg::command_e'(item_i.command))
        cbt_pkg::CmdTick: begin
          if (state_i.elapsed_ticks != cbt_pkg::CountMax) begin
            st.elapsed_ticks = state_i.elapsed_ticks + 1'b1;
          end
        end
        cbt_pkg::CmdStart, cbt_pkg::CmdExtend: begin
          // only a longer time than what is left restarts the count
          if (time_sat > remaining) begin
            st.timeout_ticks = time_sat;
            st.elapsed_ticks = '0;
          end
        end
        cbt_pkg::CmdReset: st.elapsed_ticks = '0;
        cbt_pkg::CmdCancel: begin
          ev       = cbt_pkg::EvCancel;
          st.armed = 1'b0;
        end
        cbt_pkg::CmdKill: st.armed = 1'b0;
        default: ;
      endcase
    end

    // expiry check after the command
    if (st.armed && (st.elapsed_ticks >= st.timeout_ticks)) begin
      ev = cbt_pkg::EvNormal;
      if (periodic_i) begin
        st.elapsed_ticks = '0;
      end else begin
        st.armed = 1'b0;
      end
    end
  end

  assign state_o            = st;
  assign result_o.event_res = 2'(ev);
  assign result_o.running   = st.armed;

endmodule

// ----- rtl/core/callback_timer_with_extend.sv -----
// top level of the one-shot / periodic callback timer with extend
//
//  channel | direction | handshake             | payload
//  --------+-----------+-----------------------+------------------------------------
//  in      | input     | in_valid_i/in_ready_o  | cmd_item_t: command, time_value
//  out     | output    | out_valid_o/out_ready_i| result_item_t: event_res, running
//  cfg     | input     | cfg_valid_i/cfg_ready_o| periodic_mode (1 bit)
//
// one item per cycle sustained while the output is not stalled; an accepted item is registered
// in the input register, then moves into the result register, where its result is valid
// the timer state register is updated in the cycle an item moves into the result register
// a stalled result holds the result register; the input register still takes one more item
// reset clears the timer to stopped, counts to zero and periodic_mode to one-shot
module callback_timer_with_extend (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  cbt_pkg::cmd_item_t    in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output cbt_pkg::result_item_t out_data_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic                  cfg_data_i
);

  // input stage
  logic               in_valid_q;
  cbt_pkg::cmd_item_t in_q;
  // result stage
  logic                  out_valid_q;
  cbt_pkg::result_item_t out_q;
  // timer state and mode
  cbt_pkg::timer_state_t state_q;
  cbt_pkg::timer_state_t state_d;
  cbt_pkg::result_item_t result_d;
  logic                  periodic_q;
  logic                  advance;

  // the item in the input register moves on when the result slot is free
  assign advance    = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;

  // configuration is a plain register write, always taken
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      periodic_q <= 1'b0;
    end else if (cfg_valid_i) begin
      periodic_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_q <= in_data_i;
    end
  end

  // next state and result from the registered item
  cbt_step u_step (
    .state_i    (state_q),
    .item_i     (in_q),
    .periodic_i (periodic_q),
    .state_o    (state_d),
    .result_o   (result_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else if (advance) begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q <= result_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ----- rtl/core/cbt_checker.sv -----
// port-level checks for the callback timer, bound to the top level
module cbt_checker (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  in_ready_o,
  input logic                  out_valid_o,
  input logic                  out_ready_i,
  input cbt_pkg::result_item_t out_data_o
);

  // a stalled result keeps its payload
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(out_data_o)))
    else $error("stalled result changed");

  // input back-pressure only comes from a stalled output
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (out_valid_o && !out_ready_i))
    else $error("input stalled without output stall");

  // a cancel leaves the timer stopped
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (out_data_o.event_res == 2'(cbt_pkg::EvCancel))) |-> !out_data_o.running)
    else $error("cancel reported with timer running");

  // only defined event codes
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.event_res <= 2'(cbt_pkg::EvCancel)))
    else $error("undefined event code");

endmodule

bind callback_timer_with_extend cbt_checker u_cbt_checker (.*);
